>>> rtl/lbvi_pkg.sv
// Shared types and constants of the LCS bound value iteration block.
`timescale 1ns / 1ps
package lbvi_pkg;

	// Command codes carried in s_tuser.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_SWEEP = 2'd2;

	// Result kinds carried in m_tuser.
	localparam logic [1:0] KIND_WRITE_ACK = 2'd0;
	localparam logic [1:0] KIND_READ_DATA = 2'd1;
	localparam logic [1:0] KIND_SWEEP_END = 2'd2;

	// Sweep phases: each folded entry issues four source reads.
	localparam logic [1:0] PHASE_FIRST = 2'd0;
	localparam logic [1:0] PHASE_SPLIT = 2'd2;
	localparam logic [1:0] PHASE_LAST  = 2'd3;

	// Interleaving masks: odd positions hold string A, even ones string B.
	localparam logic [63:0] ODD_BITS  = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] EVEN_BITS = 64'h5555_5555_5555_5555;

	localparam logic [31:0] UNIT_RESET = 32'd25000000;

	localparam int unsigned DATA_W = 32;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic       start;    // sweep begins, reset the running minimum
		logic       issue;    // a sweep source read is issued this cycle
		logic [1:0] phase;    // which of the four reads of the entry
		logic       match;    // entry whose first characters agree
		logic       host_wr;  // host write to the active bank
		logic       bank;     // active (source) bank
	} lbvi_ctl_t;

endpackage

>>> rtl/lbvi_agen.sv
// Tap address generator: neighbour index of a sweep entry, folded by complement symmetry.
`timescale 1ns / 1ps
module lbvi_agen #(
	parameter int STRING_LENGTH = 8
) (
	input  logic [2*STRING_LENGTH-2:0] s,
	input  logic [1:0]                 phase,
	output logic [2*STRING_LENGTH-2:0] tap,
	output logic                       match
);
	import lbvi_pkg::*;

	localparam int FULL_W = 2 * STRING_LENGTH;
	localparam int IDX_W  = FULL_W - 1;
	localparam logic [FULL_W-1:0] Q_MASK = {2'b00, {(FULL_W-2){1'b1}}};
	localparam logic [FULL_W-1:0] H_MASK = {1'b0, {(FULL_W-1){1'b1}}};
	localparam logic [FULL_W-1:0] ODD_M  = ODD_BITS[FULL_W-1:0];
	localparam logic [FULL_W-1:0] EVEN_M = EVEN_BITS[FULL_W-1:0];

	logic [FULL_W-1:0] s_f, r_f, a_b, tb, x0, ta, bb, y0, base_m, mism, raw;

	always_comb begin
		s_f    = {1'b0, s};
		r_f    = ~s_f;
		// Both first characters zero: shift both strings by one character.
		base_m = {s[IDX_W-2:0], phase};
		// Advancing string B keeps A and drops the first B character.
		a_b    = s_f & ODD_M;
		tb     = s_f & EVEN_M & Q_MASK;
		x0     = a_b | (tb << 2);
		// Advancing string A is worked out on the complement.
		ta     = r_f & ODD_M & H_MASK;
		bb     = r_f & EVEN_M;
		y0     = (ta << 2) | bb;
		case (phase)
			2'd0:    mism = x0;
			2'd1:    mism = x0 | FULL_W'(1);
			2'd2:    mism = y0;
			default: mism = y0 | FULL_W'(2);
		endcase
		match = ~s[IDX_W-1];
		raw   = match ? base_m : mism;
		// min(x, ~x) is the one whose top bit is clear.
		tap   = raw[FULL_W-1] ? ~raw[IDX_W-1:0] : raw[IDX_W-1:0];
	end

endmodule

>>> rtl/lbvi_dp.sv
// Datapath: two-bank value store, shared accumulator, update pipeline and minimum tracker.
`timescale 1ns / 1ps
module lbvi_dp #(
	parameter int STRING_LENGTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lbvi_pkg::lbvi_ctl_t        ctl,
	input  logic [2*STRING_LENGTH-2:0] s,
	input  logic [2*STRING_LENGTH-2:0] rd_idx,
	input  logic [2*STRING_LENGTH-2:0] wr_idx,
	input  logic [31:0]                wr_value,
	input  logic [31:0]                unit_value,
	output logic [31:0]                rd_data,
	output logic [31:0]                sweep_min,
	output logic                       pipe_busy
);
	import lbvi_pkg::*;

	localparam int IDX_W  = 2 * STRING_LENGTH - 1;
	localparam int ADDR_W = IDX_W + 1;
	localparam int DEPTH  = 2 ** ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rda_q, rdb_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;

	// Read tag stage, aligned with the registered read data.
	logic             vld_s1, match_s1;
	logic [1:0]       phase_s1;
	logic [IDX_W-1:0] s_s1;

	logic [33:0] acc_q, add_a, add_sum;
	logic [32:0] sx_q;
	logic        zero_sel;

	logic             vld_s2, match_s2;
	logic [33:0]      sum_s2;
	logic [32:0]      sx_s2;
	logic [31:0]      old_s2;
	logic [IDX_W-1:0] s_s2;

	logic             vld_s3;
	logic [31:0]      nv_s3, old_s3, nv_d;
	logic [32:0]      mx;
	logic [IDX_W-1:0] s_s3;

	logic        vld_s4;
	logic [31:0] diff_s4, min_q;

	// Sweep results go to the other bank; the host writes the active one.
	always_comb begin
		we    = vld_s3 | ctl.host_wr;
		waddr = vld_s3 ? {~ctl.bank, s_s3} : {ctl.bank, wr_idx};
		wdata = vld_s3 ? nv_s3 : wr_value;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rda_q <= mem[{ctl.bank, rd_idx}];
		rdb_q <= mem[{ctl.bank, s}];
	end

	assign rd_data = rda_q;

	// One adder serves all four reads of an entry.
	always_comb begin
		zero_sel = (phase_s1 == PHASE_FIRST) || ((phase_s1 == PHASE_SPLIT) && !match_s1);
		add_a    = zero_sel ? 34'd0 : acc_q;
		add_sum  = add_a + {2'b00, rda_q};
	end

	always_comb begin
		mx = (sx_s2 > sum_s2[32:0]) ? sx_s2 : sum_s2[32:0];
		nv_d = match_s2 ? (unit_value + sum_s2[33:2]) : mx[32:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			min_q  <= '1;
		end else begin
			vld_s1 <= ctl.issue;
			vld_s2 <= vld_s1 && (phase_s1 == PHASE_LAST);
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			if (ctl.start) begin
				min_q <= '1;
			end else if (vld_s4 && (diff_s4 < min_q)) begin
				min_q <= diff_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= ctl.phase;
		match_s1 <= ctl.match;
		s_s1     <= s;
		if (vld_s1) begin
			acc_q <= add_sum;
			if ((phase_s1 == PHASE_SPLIT) && !match_s1) begin
				sx_q <= acc_q[32:0];
			end
		end
		sum_s2   <= add_sum;
		sx_s2    <= sx_q;
		old_s2   <= rdb_q;
		match_s2 <= match_s1;
		s_s2     <= s_s1;
		nv_s3    <= nv_d;
		old_s3   <= old_s2;
		s_s3     <= s_s2;
		diff_s4  <= nv_s3 - old_s3;
	end

	assign sweep_min = min_q;
	assign pipe_busy = vld_s1 | vld_s2 | vld_s3 | vld_s4;

endmodule

>>> rtl/lcs_bound_value_iteration.sv
// Top level of the LCS bound value iteration block: handshakes, sequencer and configuration.
`timescale 1ns / 1ps
// Channel     | Direction | Payload
// s_*         | in        | tuser[1:0] cmd; tdata[14:0] entry_index, [46:15] entry_value
// m_*         | out       | tuser[1:0] result_kind; tdata[31:0] result_data
// cfg_*       | in        | cfg_wdata unit_value, taken whenever cfg_we is high
//
// A write passes from idle to the result state, and a read through the read state
// and the result state, before the result is registered for output. A sweep
// walks every folded entry; each needs four source reads through the single tap read port.
// Reset clears the control state and sets unit_value to 25000000; the value
// store is not cleared. While a command is in progress s_tready is low, and a
// finished result waits in the output register until m_tready takes it.
module lcs_bound_value_iteration #(
	parameter int STRING_LENGTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [14:0] entry_index, [46:15] entry_value, [47] zero
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_data
	output logic [1:0]  m_tuser,   // [1:0] result_kind
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import lbvi_pkg::*;

	localparam int IDX_W = 2 * STRING_LENGTH - 1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_SWEEP  = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t           state_q;
	logic             bank_q;
	logic [31:0]      unit_q;
	logic [IDX_W-1:0] s_q;
	logic [1:0]       phase_q;
	logic [1:0]       res_kind_q;
	logic [31:0]      res_data_q;
	logic             out_vld_q;
	logic [1:0]       out_kind_q;
	logic [31:0]      out_data_q;

	logic             accept;
	logic [1:0]       cmd;
	logic [IDX_W-1:0] idx;
	logic [31:0]      value;
	logic [IDX_W-1:0] tap, rd_idx;
	logic             match;
	logic [31:0]      rd_data, sweep_min;
	logic             pipe_busy;
	lbvi_ctl_t        ctl;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign cmd      = s_tuser;
	// Indices beyond the folded range wrap to their low bits.
	assign idx      = IDX_W'(s_tdata[14:0]);
	assign value    = s_tdata[46:15];

	lbvi_agen #(
		.STRING_LENGTH(STRING_LENGTH)
	) u_agen (
		.s    (s_q),
		.phase(phase_q),
		.tap  (tap),
		.match(match)
	);

	// The tap port serves host reads outside a sweep.
	assign rd_idx = (state_q == ST_SWEEP) ? tap : idx;

	always_comb begin
		ctl.start   = accept && (cmd == CMD_SWEEP);
		ctl.issue   = (state_q == ST_SWEEP);
		ctl.phase   = phase_q;
		ctl.match   = match;
		ctl.host_wr = accept && (cmd == CMD_WRITE);
		ctl.bank    = bank_q;
	end

	lbvi_dp #(
		.STRING_LENGTH(STRING_LENGTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.s         (s_q),
		.rd_idx    (rd_idx),
		.wr_idx    (idx),
		.wr_value  (value),
		.unit_value(unit_q),
		.rd_data   (rd_data),
		.sweep_min (sweep_min),
		.pipe_busy (pipe_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UNIT_RESET;
		end else if (cfg_we) begin
			unit_q <= cfg_wdata;
		end
	end

	// Sequencer: one command at a time, the sweep walks entries four phases each.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bank_q    <= 1'b0;
			s_q       <= '0;
			phase_q   <= PHASE_FIRST;
			out_vld_q <= 1'b0;
		end else begin
			// The result state refills the output register itself.
			if (out_vld_q && m_tready && (state_q != ST_RESULT)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_WRITE: begin
								state_q <= ST_RESULT;
							end
							CMD_READ: begin
								state_q <= ST_READ;
							end
							CMD_SWEEP: begin
								s_q     <= '0;
								phase_q <= PHASE_FIRST;
								state_q <= ST_SWEEP;
							end
							default: begin
								// The unused command is dropped without a result.
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_RESULT;
				end
				ST_SWEEP: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == PHASE_LAST) begin
						s_q <= s_q + IDX_W'(1);
						if (s_q == '1) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						bank_q  <= ~bank_q;
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (!out_vld_q || m_tready) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result staging and output register payload.
	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_WRITE)) begin
			res_kind_q <= KIND_WRITE_ACK;
			res_data_q <= '0;
		end
		if (state_q == ST_READ) begin
			res_kind_q <= KIND_READ_DATA;
			res_data_q <= rd_data;
		end
		if ((state_q == ST_DRAIN) && !pipe_busy) begin
			res_kind_q <= KIND_SWEEP_END;
			res_data_q <= sweep_min;
		end
		if ((state_q == ST_RESULT) && (!out_vld_q || m_tready)) begin
			out_kind_q <= res_kind_q;
			out_data_q <= res_data_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = out_data_q;

endmodule

>>> verif/tb_lcs_bound_value_iteration.sv
// Self-checking testbench for the LCS bound value iteration block.
`timescale 1ns / 1ps
module tb_lcs_bound_value_iteration;
	import lbvi_pkg::*;

	// The block is tested at its default string length. With that length a sweep
	// walks all 32768 folded entries, so the run holds only a handful of them and
	// fills the store once, entry by entry, before the first one.
	localparam int unsigned STR_LEN = 8;
	localparam int unsigned FULL_BITS = 2 * STR_LEN;
	localparam longint unsigned HALF_COUNT = 64'd1 << (FULL_BITS - 1);
	localparam longint unsigned QUARTER_COUNT = 64'd1 << (FULL_BITS - 2);
	localparam longint unsigned FULL_MASK = (64'd1 << FULL_BITS) - 64'd1;
	localparam longint unsigned SWEEP_CYCLES = 4 * HALF_COUNT + 7;

	// A code the block does not know: it must be swallowed without a result.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam longint unsigned WATCHDOG_LIMIT = 3 * (SWEEP_CYCLES + HOLD_CYCLES + 20);

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] data;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // [14:0] entry_index, [46:15] entry_value, [47] zero
	logic [1:0]  s_tuser;   // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] result_data
	logic [1:0]  m_tuser;   // [1:0] result_kind
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	// Predicted contents of both banks, the active bank and the unit value.
	bit [31:0] value_banks [0:2*HALF_COUNT-1];
	bit        active_bank;
	bit [31:0] unit_q;

	result_t expected_results[$];

	bit          src_idle_en;
	bit          sink_idle_en;
	bit          hold_off_req;
	int unsigned fail_count;
	int unsigned results_checked;
	int unsigned cmds_sent;
	int unsigned sweeps_sent;
	int unsigned ignored_sent;
	int unsigned unit_settings;
	longint unsigned idle_cycles;

	lcs_bound_value_iteration #(
		.STRING_LENGTH(STR_LEN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	// Looks an entry up in the source bank after folding the index by complement
	// symmetry, so that x and ~x share one stored word.
	function automatic bit [31:0] folded_entry(bit bank_sel, longint unsigned x);
		longint unsigned y, c, f;
		y = x & FULL_MASK;
		c = FULL_MASK - y;
		f = (c < y) ? c : y;
		f = f & (HALF_COUNT - 1);
		return value_banks[longint'(bank_sel) * HALF_COUNT + f];
	endfunction

	// One full sweep from the active bank into the other one. Returns the smallest
	// change (new minus old, wrapping) over every folded entry and swaps the banks.
	function automatic bit [31:0] compute_sweep();
		bit              src, dst;
		bit [31:0]       least_diff, nv, old_v, diff;
		longint unsigned s, base, sum, a, tb, x0, x1, r, ta, bb, y0, y1, sx, sy;
		src = active_bank;
		dst = ~active_bank;
		least_diff = '1;
		for (s = 0; s < HALF_COUNT; s++) begin
			old_v = value_banks[longint'(src) * HALF_COUNT + s];
			if (s < QUARTER_COUNT) begin
				// Both first characters are zero: one unit plus the mean of the
				// four entries reached by dropping both first characters.
				base = (s & (QUARTER_COUNT - 1)) << 2;
				sum = longint'(folded_entry(src, base)) + folded_entry(src, base | 1)
					+ folded_entry(src, base | 2) + folded_entry(src, base | 3);
				nv = unit_q + 32'(sum >> 2);
			end else begin
				// First characters differ: the better of advancing B or advancing A.
				a = s & ODD_BITS & FULL_MASK;
				tb = s & EVEN_BITS & (QUARTER_COUNT - 1);
				x0 = a | (tb << 2);
				x1 = x0 | 1;
				r = FULL_MASK - s;
				ta = r & ODD_BITS & (HALF_COUNT - 1);
				bb = r & EVEN_BITS;
				y0 = (ta << 2) | bb;
				y1 = y0 | 2;
				sx = longint'(folded_entry(src, x0)) + folded_entry(src, x1);
				sy = longint'(folded_entry(src, y0)) + folded_entry(src, y1);
				nv = 32'(((sx > sy) ? sx : sy) >> 1);
			end
			value_banks[longint'(dst) * HALF_COUNT + s] = nv;
			diff = nv - old_v;
			if (diff < least_diff)
				least_diff = diff;
		end
		active_bank = dst;
		return least_diff;
	endfunction

	// Applies one accepted command to the predicted state and queues its result.
	function automatic void predict_command(logic [1:0] cmd, logic [14:0] idx, logic [31:0] val);
		result_t         res;
		longint unsigned slot;
		slot = longint'(active_bank) * HALF_COUNT + (longint'(idx) & (HALF_COUNT - 1));
		cmds_sent++;
		case (cmd)
			CMD_WRITE: begin
				value_banks[slot] = val;
				res.kind = KIND_WRITE_ACK;
				res.data = '0;
				expected_results.push_back(res);
			end
			CMD_READ: begin
				res.kind = KIND_READ_DATA;
				res.data = value_banks[slot];
				expected_results.push_back(res);
			end
			CMD_SWEEP: begin
				sweeps_sent++;
				res.kind = KIND_SWEEP_END;
				res.data = compute_sweep();
				expected_results.push_back(res);
			end
			default: ignored_sent++;
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [14:0] random_index();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 15'(HALF_COUNT - 1);
			default: return 15'($urandom_range(0, int'(HALF_COUNT - 1)));
		endcase
	endfunction

	// Offers one transaction and returns once it has been accepted. The valid
	// line is left high; the next call, or a drain, decides what it does next.
	task automatic send_cmd(input logic [1:0] cmd, input logic [14:0] idx, input logic [31:0] val);
		int unsigned gap;
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {1'b0, val, idx};
		do @(posedge clk); while (!s_tready);
		predict_command(cmd, idx, val);
	endtask

	// Stops offering, waits for every outstanding result, then lets a few more
	// cycles pass in case an ignored command is still occupying the block.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The unit value is only ever changed while the block is idle.
	task automatic set_unit_value(input logic [31:0] value);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		unit_q = value;
		unit_settings++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests

	// Writes and reads at the corners of the index and value ranges. The store is
	// not cleared by reset, so only entries written here are read back.
	task automatic test_write_read_extremes();
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		send_cmd(CMD_WRITE, 15'h0000, 32'h0000_0000);
		send_cmd(CMD_WRITE, 15'(HALF_COUNT - 1), 32'hFFFF_FFFF);
		send_cmd(CMD_WRITE, 15'h2AAA, 32'h5555_5555);
		send_cmd(CMD_WRITE, 15'h5555, 32'hAAAA_AAAA);
		send_cmd(CMD_WRITE, 15'(QUARTER_COUNT - 1), random_word());
		send_cmd(CMD_WRITE, 15'(QUARTER_COUNT), random_word());
		send_cmd(CMD_READ, 15'h0000, 32'hFFFF_FFFF);
		send_cmd(CMD_READ, 15'(HALF_COUNT - 1), 32'h0000_0000);
		send_cmd(CMD_READ, 15'h2AAA, random_word());
		send_cmd(CMD_READ, 15'h5555, random_word());
		send_cmd(CMD_READ, 15'(QUARTER_COUNT - 1), random_word());
		send_cmd(CMD_READ, 15'(QUARTER_COUNT), random_word());
		send_cmd(CMD_WRITE, 15'h0000, 32'hFFFF_FFFF);
		send_cmd(CMD_READ, 15'h0000, random_word());
		drain_results();
	endtask

	// The unused code must leave no result and no trace in the store.
	task automatic test_unused_command();
		send_cmd(CMD_UNUSED, 15'h7FFF, 32'hFFFF_FFFF);
		send_cmd(CMD_UNUSED, 15'h0000, 32'h0000_0000);
		send_cmd(CMD_READ, 15'h0000, random_word());
		send_cmd(CMD_READ, 15'(HALF_COUNT - 1), random_word());
		drain_results();
	endtask

	// Every folded entry of the active bank has to hold a value before any sweep.
	task automatic test_fill_store();
		longint unsigned i;
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		for (i = 0; i < HALF_COUNT; i++)
			send_cmd(CMD_WRITE, 15'(i), random_word());
		drain_results();
	endtask

	// Sweeps at the reset unit value and at both extremes, the all-ones one making
	// the match sums wrap. A few reads after each look at the freshly swapped bank.
	task automatic test_sweep_units();
		int unsigned k, j;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		for (k = 0; k < 3; k++) begin
			if (k == 1)
				set_unit_value(32'h0000_0000);
			if (k == 2)
				set_unit_value(32'hFFFF_FFFF);
			send_cmd(CMD_SWEEP, random_index(), random_word());
			send_cmd(CMD_READ, 15'h0000, random_word());
			for (j = 0; j < 3; j++)
				send_cmd(CMD_READ, random_index(), random_word());
		end
		drain_results();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering,
	// so the block fills up and stalls its input. Afterwards the sender pauses
	// until everything is back before it resumes.
	task automatic test_back_pressure();
		int unsigned j;
		src_idle_en = 1'b0;
		hold_off_req = 1'b1;
		for (j = 0; j < 10; j++)
			send_cmd((j % 2 == 0) ? CMD_WRITE : CMD_READ, random_index(), random_word());
		drain_results();
		src_idle_en = 1'b1;
		for (j = 0; j < 4; j++)
			send_cmd(CMD_READ, random_index(), random_word());
		drain_results();
	endtask

	// Mixed traffic in three settings of the unit value. The middle one carries a
	// single sweep, and the last one runs with neither side idling.
	task automatic test_random_traffic();
		int unsigned ph, counted, sweep_slot, pick;
		for (ph = 0; ph < 3; ph++) begin
			set_unit_value(random_word());
			src_idle_en = (ph < 2);
			sink_idle_en = (ph < 2);
			sweep_slot = $urandom_range(5, 30);
			counted = 0;
			while (counted < 34) begin
				pick = $urandom_range(0, 19);
				if (ph == 1 && counted == sweep_slot) begin
					send_cmd(CMD_SWEEP, random_index(), random_word());
					counted++;
				end else if (pick < 9) begin
					send_cmd(CMD_WRITE, random_index(), random_word());
					counted++;
				end else if (pick < 18) begin
					send_cmd(CMD_READ, random_index(), random_word());
					counted++;
				end else begin
					send_cmd(CMD_UNUSED, random_index(), random_word());
				end
			end
		end
		drain_results();
	endtask

	// ---------------------------------------------------------------- receiver side

	// Drives m_tready: random stall bursts when enabled, and one long hold-off on
	// request, its length counted here rather than by the sender.
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
				hold_off_req = 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Each result transaction is compared with the oldest prediction.
	always @(posedge clk) begin : check_result
		result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("Result with nothing expected: result_kind %0d, result_data 0x%08h",
					m_tuser, m_tdata);
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				results_checked++;
				if (m_tuser !== exp_r.kind) begin
					$error("result_kind mismatch: expected %0d, actual %0d", exp_r.kind, m_tuser);
					fail_count++;
				end
				if (m_tdata !== exp_r.data) begin
					$error("result_data mismatch: expected 0x%08h, actual 0x%08h",
						exp_r.data, m_tdata);
					fail_count++;
				end
			end
		end
	end

	// A sweep is long, so the limit on cycles without any transaction is a few
	// sweeps plus the longest stall.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d results outstanding.",
					expected_results.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		hold_off_req = 1'b0;
		fail_count = 0;
		results_checked = 0;
		cmds_sent = 0;
		sweeps_sent = 0;
		ignored_sent = 0;
		unit_settings = 0;
		active_bank = 1'b0;
		unit_q = UNIT_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_write_read_extremes();
		test_unused_command();
		test_fill_store();
		test_sweep_units();
		test_back_pressure();
		test_random_traffic();

		drain_results();
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		$display("Sent %0d commands (%0d sweeps, %0d of the unused code), checked %0d results.",
			cmds_sent, sweeps_sent, ignored_sent, results_checked);
		$display("Unit value written %0d times; long receiver hold-off and sender pause done.",
			unit_settings);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
